// ----- sv/prle_pkg.sv -----
// Shared types and constants for the palette run-length crop decoder.
// Holds the channel payload structs, register indexes and fixed field widths.
// No dependencies.
package prle_pkg;

	localparam int CODE_W  = 8;
	localparam int RUN_W   = 7;
	localparam int CFG_W   = 11;
	localparam int CALC_W  = 12;
	localparam int COLOR_W = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_CODE = 1'b1;

	localparam logic [2:0] CFG_INDEX_BITS   = 3'd0;
	localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd1;
	localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd2;
	localparam logic [2:0] CFG_WINDOW_X     = 3'd3;
	localparam logic [2:0] CFG_WINDOW_Y     = 3'd4;
	localparam logic [2:0] CFG_WINDOW_W     = 3'd5;
	localparam logic [2:0] CFG_WINDOW_H     = 3'd6;

	localparam logic [2:0] MIN_INDEX_BITS = 3'd2;

	typedef struct packed {
		logic                req_type;
		logic [6:0]          palette_slot;
		logic [COLOR_W-1:0]  palette_value;
		logic [CODE_W-1:0]   code_byte;
	} in_item_t;

	typedef struct packed {
		logic [COLOR_W-1:0] pixel_color;
		logic               last_of_input;
		logic               row_end;
		logic               window_end;
	} out_item_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [RUN_W-1:0]   run;
	} run_entry_t;

	typedef struct packed {
		logic [CFG_W-1:0] frame_width;
		logic [CFG_W-1:0] frame_height;
		logic [9:0]       window_x;
		logic [9:0]       window_y;
		logic [CFG_W-1:0] window_w;
		logic [CFG_W-1:0] window_h;
	} geom_t;

endpackage

// ----- sv/prle_front.sv -----
// Front end: accepts items, applies palette loads, decodes code bytes.
// Owns the palette memory and pushes {color, run} entries to the queue.
// Depends on prle_pkg.
module prle_front #(
	parameter int PALETTE_DEPTH = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  prle_pkg::in_item_t  in_item,
	input  logic [2:0]          index_bits,
	output logic                q_push,
	output prle_pkg::run_entry_t q_entry,
	input  logic                q_full
);
	import prle_pkg::*;

	localparam int PAL_AW = $clog2(PALETTE_DEPTH);

	logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH];
	logic [COLOR_W-1:0] pal_rd_s1;
	logic               valid_s1;
	logic               oob_s1;
	logic [RUN_W-1:0]   run_s1;

	logic               accept;
	logic               acc_load;
	logic               acc_code;
	logic [2:0]         bits;
	logic [2:0]         run_bits;
	logic [CODE_W-1:0]  idx_full;
	logic [CODE_W-1:0]  run_mask;
	logic [RUN_W-1:0]   run_len;
	logic               slot_ok;
	logic               idx_ok;

	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign acc_load = accept && (in_item.req_type == REQ_LOAD);
	assign acc_code = accept && (in_item.req_type == REQ_CODE);

	assign bits     = (index_bits < MIN_INDEX_BITS) ? MIN_INDEX_BITS : index_bits;
	assign run_bits = 3'(CODE_W) - bits;
	assign idx_full = in_item.code_byte >> run_bits;
	assign run_mask = (CODE_W'(1) << run_bits) - CODE_W'(1);
	assign run_len  = RUN_W'(in_item.code_byte & run_mask) + RUN_W'(1);
	assign slot_ok  = CODE_W'(in_item.palette_slot) < CODE_W'(PALETTE_DEPTH);
	assign idx_ok   = idx_full < CODE_W'(PALETTE_DEPTH);

	assign q_push        = valid_s1 && !q_full;
	assign q_entry.color = oob_s1 ? '0 : pal_rd_s1;
	assign q_entry.run   = run_s1;

	always_ff @(posedge clk) begin
		if (acc_load && slot_ok) begin
			pal_mem[in_item.palette_slot[PAL_AW-1:0]] <= in_item.palette_value;
		end
		if (acc_code) begin
			pal_rd_s1 <= pal_mem[idx_full[PAL_AW-1:0]];
			oob_s1    <= !idx_ok;
			run_s1    <= run_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc_code) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

// ----- sv/prle_queue.sv -----
// Short FIFO of decoded runs between the front and back ends.
// Depth is QUEUE_DEPTH from prle_pkg.
// Depends on prle_pkg.
module prle_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  prle_pkg::run_entry_t push_data,
	output logic                 full,
	input  logic                 pop,
	output prle_pkg::run_entry_t pop_data,
	output logic                 empty
);
	import prle_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	run_entry_t       slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- sv/prle_back.sv -----
// Back end: walks each run one pixel per cycle unless the output stalls, tracks frame position,
// crops to the window and drives the result register. Depends on prle_pkg.
module prle_back #(
	parameter int MAX_SIDE = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  prle_pkg::geom_t      geom,
	input  logic                 q_empty,
	input  prle_pkg::run_entry_t q_data,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output prle_pkg::out_item_t  out_item
);
	import prle_pkg::*;

	localparam int CFG_MAX   = (1 << CFG_W) - 1;
	localparam int CLAMP_MAX = (MAX_SIDE < CFG_MAX) ? MAX_SIDE : CFG_MAX;
	localparam int POS_W     = $clog2(CLAMP_MAX);

	function automatic logic [CALC_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
		logic [CALC_W-1:0] r;
		r = CALC_W'(v);
		if (v == '0) begin
			r = CALC_W'(1);
		end else if (r > CALC_W'(CLAMP_MAX)) begin
			r = CALC_W'(CLAMP_MAX);
		end
		return r;
	endfunction

	logic [CALC_W-1:0]  fw_q, fh_q, wx_q, wy_q, xend_q, yend_q;
	logic [CALC_W-1:0]  fw_c, fh_c, xsum_c, ysum_c;

	logic               active_q;
	logic [RUN_W-1:0]   run_q;
	logic [COLOR_W-1:0] color_q;
	logic [POS_W-1:0]   col_q;
	logic [POS_W-1:0]   row_q;

	logic               h_valid_q;
	logic               h_fin_q;
	out_item_t          h_item_q;
	logic               out_valid_q;
	out_item_t          out_item_q;

	logic [CALC_W-1:0]  col_c, row_c, col_inc, row_inc;
	logic               in_win, rend, wend, col_wrap, row_wrap, byte_end;
	logic               o_avail, step, h_move, load;

	assign fw_c   = clamp_side(geom.frame_width);
	assign fh_c   = clamp_side(geom.frame_height);
	assign xsum_c = CALC_W'(geom.window_x) + CALC_W'(geom.window_w);
	assign ysum_c = CALC_W'(geom.window_y) + CALC_W'(geom.window_h);

	always_ff @(posedge clk) begin
		fw_q   <= fw_c;
		fh_q   <= fh_c;
		wx_q   <= CALC_W'(geom.window_x);
		wy_q   <= CALC_W'(geom.window_y);
		xend_q <= (xsum_c < fw_c) ? xsum_c : fw_c;
		yend_q <= (ysum_c < fh_c) ? ysum_c : fh_c;
	end

	assign col_c    = CALC_W'(col_q);
	assign row_c    = CALC_W'(row_q);
	assign col_inc  = col_c + CALC_W'(1);
	assign row_inc  = row_c + CALC_W'(1);
	assign in_win   = (col_c >= wx_q) && (col_c < xend_q) && (row_c >= wy_q) && (row_c < yend_q);
	assign rend     = col_inc == xend_q;
	assign wend     = rend && (row_inc == yend_q);
	assign col_wrap = col_inc >= fw_q;
	assign row_wrap = col_wrap && (row_inc >= fh_q);
	assign byte_end = (run_q == RUN_W'(1)) || row_wrap;

	assign o_avail = !out_valid_q || !out_stall;
	assign step    = active_q && (!in_win || !h_valid_q || o_avail);
	assign h_move  = h_valid_q && o_avail && (h_fin_q || (step && in_win));
	assign load    = !q_empty && (!active_q || (step && byte_end));
	assign q_pop   = load;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk) begin
		if (load) begin
			color_q <= q_data.color;
		end
		if (h_move) begin
			out_item_q <= {h_item_q.pixel_color, h_fin_q, h_item_q.row_end,
				h_item_q.window_end};
		end
		if (step && in_win) begin
			h_item_q <= {color_q, 1'b0, rend, wend};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			run_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			h_valid_q   <= 1'b0;
			h_fin_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				active_q <= 1'b1;
				run_q    <= q_data.run;
			end else if (step && byte_end) begin
				active_q <= 1'b0;
			end else if (step) begin
				run_q <= run_q - RUN_W'(1);
			end

			if (step) begin
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : POS_W'(row_inc);
				end else begin
					col_q <= POS_W'(col_inc);
				end
			end

			if (step && in_win) begin
				h_valid_q <= 1'b1;
				h_fin_q   <= byte_end;
			end else if (h_move) begin
				h_valid_q <= 1'b0;
				h_fin_q   <= 1'b0;
			end else if (step && byte_end) begin
				h_fin_q <= h_valid_q;
			end

			if (h_move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_held_open_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		(h_valid_q && !h_fin_q) |-> active_q)
		else $error("held pixel not final but no run in progress");

	a_active_has_run: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (run_q != '0))
		else $error("active run with zero remaining pixels");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty run queue");

	a_window_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_item_q.window_end || out_item_q.row_end))
		else $error("window end without row end");

	a_fin_empty_clears: assert property (@(posedge clk) disable iff (!arst_n)
		!h_valid_q |-> !h_fin_q)
		else $error("final flag set on empty hold register");
`endif

endmodule

// ----- sv/palette_rle_window_crop_decoder_core.sv -----
// Palette run-length decoder with a crop window. A palette load is written to
// the palette memory when accepted. A code byte passes the front end (palette
// read, one register stage) into a four-entry run queue; the back end then
// walks the run at one pixel per cycle unless the output stalls, so a byte of
// run length n (1 to 64) covers n pixels, fewer when the frame completes
// inside the run. Sustained throughput is set by the back-end walker: one
// decoded pixel per clock while the output is not stalled, whether or not
// the pixel lands in the window. Results are held one pixel deep so the last
// result of each byte can be marked; a result leaves through a registered
// output stage. Configuration writes must be made while the block is idle.
module palette_rle_window_crop_decoder_core #(
	parameter int MAX_SIDE      = 1024,
	parameter int PALETTE_DEPTH = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [2:0]          cfg_index,
	input  logic [10:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  prle_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output prle_pkg::out_item_t out_item
);
	import prle_pkg::*;

	logic [2:0] index_bits_q;
	geom_t      geom_q;
	logic       q_push, q_full, q_pop, q_empty;
	run_entry_t q_in, q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q        <= 3'd4;
			geom_q.frame_width  <= CFG_W'(1024);
			geom_q.frame_height <= CFG_W'(1024);
			geom_q.window_x     <= '0;
			geom_q.window_y     <= '0;
			geom_q.window_w     <= CFG_W'(1024);
			geom_q.window_h     <= CFG_W'(1024);
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_INDEX_BITS:   index_bits_q        <= cfg_data[2:0];
				CFG_FRAME_WIDTH:  geom_q.frame_width  <= cfg_data;
				CFG_FRAME_HEIGHT: geom_q.frame_height <= cfg_data;
				CFG_WINDOW_X:     geom_q.window_x     <= cfg_data[9:0];
				CFG_WINDOW_Y:     geom_q.window_y     <= cfg_data[9:0];
				CFG_WINDOW_W:     geom_q.window_w     <= cfg_data;
				CFG_WINDOW_H:     geom_q.window_h     <= cfg_data;
				default: ;
			endcase
		end
	end

	prle_front #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.index_bits (index_bits_q),
		.q_push     (q_push),
		.q_entry    (q_in),
		.q_full     (q_full)
	);

	prle_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	prle_back #(
		.MAX_SIDE(MAX_SIDE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom_q),
		.q_empty   (q_empty),
		.q_data    (q_out),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule
